FILE: design/spwm_pkg.sv
// Shared constants, types and the sine table for the sinusoidal PWM duty generator.
package spwm_pkg;

    // Field widths of the streams and of the configuration port.
    localparam int BUS_BITS       = 16;
    localparam int DUTY_OUT_BITS  = 16;
    localparam int S_TDATA_BITS   = 24;
    localparam int M_TDATA_BITS   = 24;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    // Bit positions inside the stream words.
    localparam int IN_ENABLE_BIT  = 0;
    localparam int IN_BUS_LSB     = 1;

    // Generator state and register widths.
    localparam int TICK_BITS      = 16;
    localparam int AMP_BITS       = 32;
    localparam int AMP_STEP_BITS  = 24;
    localparam int PHASE_BITS     = 16;

    // Sine table geometry and duty resolution.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_MAG_BITS    = 16;
    localparam int DUTY_BITS        = 16;

    // Serial multiplier: amplitude times sine magnitude.
    localparam int MUL_A_BITS   = AMP_BITS;
    localparam int MUL_B_BITS   = SINE_MAG_BITS;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS + 1);

    // Serial divider: 48-bit product over the bus voltage, 32 quotient bits.
    localparam int DIV_Q_BITS   = 32;
    localparam int DIV_CNT_BITS = $clog2(DIV_Q_BITS + 1);

    localparam logic [DIV_Q_BITS-1:0] Q_HALF = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_TICKS     = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE_STEP = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_AMPLITUDE = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP     = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [TICK_BITS-1:0]     RST_RAMP_TICKS     = 16'd25000;
    localparam logic [AMP_STEP_BITS-1:0] RST_AMPLITUDE_STEP = 24'd11389;
    localparam logic [AMP_BITS-1:0]      RST_PEAK_AMPLITUDE = 32'd284718751;
    localparam logic [PHASE_BITS-1:0]    RST_PHASE_STEP     = 16'd131;

    // Quarter-wave polynomial coefficients, Q30.
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] C1      = 64'd1686629713;
    localparam logic [63:0] C3      = 64'd693598669;
    localparam logic [63:0] C5      = 64'd85569306;
    localparam logic [63:0] C7      = 64'd5026996;
    localparam logic [63:0] C9      = 64'd172274;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROM,
        ST_MSTART,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DUTY
    } spwm_state_t;

    // One table word: sign in the top bit, magnitude 0..32768 below it.
    typedef logic [SINE_MAG_BITS:0] sine_word_t;
    typedef sine_word_t sine_rom_t [SINE_TABLE_DEPTH];

    function automatic sine_word_t sine_entry(input int unsigned idx);
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] s15;
        logic [1:0]  quad;
        logic        neg;
        t    = 64'(idx) << (32 - SINE_ADDR_BITS);
        quad = t[31:30];
        r    = t & (Q30_ONE - 64'd1);
        z    = quad[0] ? (Q30_ONE - r) : r;
        z2   = (z * z) >> 30;
        p    = C9;
        p    = C7 - ((z2 * p) >> 30);
        p    = C5 - ((z2 * p) >> 30);
        p    = C3 - ((z2 * p) >> 30);
        p    = C1 - ((z2 * p) >> 30);
        s    = (z * p) >> 30;
        s15  = (s + 64'd16384) >> 15;
        if (s15 > 64'd32768) begin
            s15 = 64'd32768;
        end
        neg  = quad[1] && (s15 != 64'd0);
        return {neg, s15[SINE_MAG_BITS-1:0]};
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        int unsigned i;
        for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: design/spwm_sine_rom.sv
// Sine table with a registered read port.
module spwm_sine_rom (
    input  logic                              aclk,
    input  logic [spwm_pkg::SINE_ADDR_BITS-1:0] addr,
    output spwm_pkg::sine_word_t              data
);
    import spwm_pkg::*;

    sine_word_t data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

FILE: design/spwm_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module spwm_serial_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [spwm_pkg::MUL_A_BITS-1:0] a,
    input  logic [spwm_pkg::MUL_B_BITS-1:0] b,
    output logic                          done,
    output logic [spwm_pkg::MUL_P_BITS-1:0] product
);
    import spwm_pkg::*;

    logic [MUL_CNT_BITS-1:0] cnt_reg;
    logic                    done_reg;
    logic [MUL_A_BITS-1:0]   a_reg;
    logic [MUL_P_BITS-1:0]   acc_reg;
    logic [MUL_A_BITS:0]     hi_sum;
    logic [MUL_P_BITS-1:0]   acc_next;

    // Upper half accumulates the multiplicand; the multiplier shifts out below.
    always_comb begin
        hi_sum   = {1'b0, acc_reg[MUL_P_BITS-1:MUL_B_BITS]}
                 + {1'b0, (acc_reg[0] ? a_reg : {MUL_A_BITS{1'b0}})};
        acc_next = {hi_sum, acc_reg[MUL_B_BITS-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == MUL_CNT_BITS'(1));
            if (start) begin
                cnt_reg <= MUL_CNT_BITS'(MUL_B_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - MUL_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            acc_reg <= {{MUL_A_BITS{1'b0}}, b};
        end else if (cnt_reg != '0) begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: design/spwm_serial_div.sv
// Restoring divider, one quotient bit per cycle.
module spwm_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [spwm_pkg::MUL_P_BITS-1:0] dividend,
    input  logic [spwm_pkg::BUS_BITS-1:0]   divisor,
    output logic                          done,
    output logic [spwm_pkg::DIV_Q_BITS-1:0] quotient
);
    import spwm_pkg::*;

    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    done_reg;
    logic [BUS_BITS-1:0]     divisor_reg;
    logic [BUS_BITS-1:0]     rem_reg;
    logic [DIV_Q_BITS-1:0]   dvd_reg;
    logic [BUS_BITS:0]       trial;
    logic [BUS_BITS:0]       diff;
    logic                    ge;

    // The caller guarantees the upper dividend bits are below the divisor,
    // so the quotient fits in DIV_Q_BITS.
    always_comb begin
        trial = {rem_reg, dvd_reg[DIV_Q_BITS-1]};
        diff  = trial - {1'b0, divisor_reg};
        ge    = (trial >= {1'b0, divisor_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == DIV_CNT_BITS'(1));
            if (start) begin
                cnt_reg <= DIV_CNT_BITS'(DIV_Q_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg <= divisor;
            rem_reg     <= dividend[MUL_P_BITS-1:DIV_Q_BITS];
            dvd_reg     <= dividend[DIV_Q_BITS-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[BUS_BITS-1:0] : trial[BUS_BITS-1:0];
            dvd_reg <= {dvd_reg[DIV_Q_BITS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: design/sine_pwm_duty_soft_start_top.sv
// Top level of the sinusoidal PWM duty generator with soft-start ramp.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready  | s_tdata: enable[0], bus_voltage[16:1]
//  m_      | out       | m_tvalid / m_tready  | m_tdata: duty[15:0], ramp_done[16]
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index (register), cfg_data (value)
//
// A tick with enable low is taken and produces no result.
// An enabled tick reads the sine table, runs the serial multiplier and then the
// serial divider, loads its result into the output register and returns to
// idle, where the next tick can be taken. When the product is zero or the ratio
// saturates, the divider is skipped.
// Reset is synchronous on aresetn low; it clears the control state and restores
// the register defaults. A result waiting on m_tready does not block the next
// tick; only its final output load waits for the result register to free up.
module sine_pwm_duty_soft_start_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: enable (bit 0), bus_voltage (bits 16:1), zero fill above.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spwm_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // m_tdata: duty (bits 15:0), ramp_done (bit 16), zero fill above.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spwm_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spwm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [spwm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import spwm_pkg::*;

    // Configuration registers.
    logic [TICK_BITS-1:0]     ramp_ticks_reg;
    logic [AMP_STEP_BITS-1:0] amp_step_reg;
    logic [AMP_BITS-1:0]      peak_reg;
    logic [PHASE_BITS-1:0]    phase_step_reg;

    // Generator state and per-tick working registers.
    spwm_state_t              state_reg, state_next;
    logic [TICK_BITS-1:0]     tick_reg, tick_next;
    logic [AMP_BITS-1:0]      amp_reg, amp_next;
    logic [PHASE_BITS-1:0]    phase_reg, phase_next;
    logic                     ramp_done_reg, ramp_done_next;
    logic [BUS_BITS-1:0]      bus_reg, bus_next;
    logic                     neg_reg, neg_next;
    logic [DIV_Q_BITS-1:0]    q_reg, q_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0]  m_tdata_reg, m_tdata_next;

    // Datapath signals.
    sine_word_t               rom_word;
    logic                     mul_start;
    logic                     mul_done;
    logic [MUL_P_BITS-1:0]    product;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_Q_BITS-1:0]    quotient;
    logic [AMP_BITS:0]        amp_sum;
    logic [TICK_BITS-1:0]     tick_inc;
    logic [DIV_Q_BITS:0]      d_val;
    logic [DIV_Q_BITS+DUTY_BITS:0] d_scaled;
    logic [DUTY_OUT_BITS-1:0] duty_val;

    // The user must issue configuration writes only while the generator is idle;
    // the block does not enforce this, and the port can always take a transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_ticks_reg <= RST_RAMP_TICKS;
            amp_step_reg   <= RST_AMPLITUDE_STEP;
            peak_reg       <= RST_PEAK_AMPLITUDE;
            phase_step_reg <= RST_PHASE_STEP;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RAMP_TICKS:     ramp_ticks_reg <= cfg_data[TICK_BITS-1:0];
                CFG_AMPLITUDE_STEP: amp_step_reg   <= cfg_data[AMP_STEP_BITS-1:0];
                CFG_PEAK_AMPLITUDE: peak_reg       <= cfg_data[AMP_BITS-1:0];
                CFG_PHASE_STEP:     phase_step_reg <= cfg_data[PHASE_BITS-1:0];
                default: begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    // The table is addressed by the top bits of the phase; the phase only
    // changes when a tick is taken, so the read word is stable afterwards.
    spwm_sine_rom u_rom (
        .aclk (aclk),
        .addr (phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .data (rom_word)
    );

    spwm_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (amp_reg),
        .b       (rom_word[SINE_MAG_BITS-1:0]),
        .done    (mul_done),
        .product (product)
    );

    spwm_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (bus_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Ramp arithmetic: saturating amplitude add and the counter increment.
    assign amp_sum  = {1'b0, amp_reg} + {{(AMP_BITS + 1 - AMP_STEP_BITS){1'b0}}, amp_step_reg};
    assign tick_inc = tick_reg + TICK_BITS'(1);

    // Duty mapping: D = half +/- q, then D * (2^DUTY_BITS - 1) / 2^32 done as
    // a shift and a subtract.
    always_comb begin
        d_val    = neg_reg ? ({1'b0, Q_HALF} - {1'b0, q_reg})
                           : ({1'b0, Q_HALF} + {1'b0, q_reg});
        d_scaled = {d_val, {DUTY_BITS{1'b0}}} - {{DUTY_BITS{1'b0}}, d_val};
        duty_val = DUTY_OUT_BITS'(d_scaled[DIV_Q_BITS +: DUTY_BITS]);
    end

    always_comb begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        amp_next       = amp_reg;
        phase_next     = phase_reg;
        ramp_done_next = ramp_done_reg;
        bus_next       = bus_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    bus_next = s_tdata[IN_BUS_LSB +: BUS_BITS];
                    if (s_tdata[IN_ENABLE_BIT]) begin
                        // The counter holds once it reaches the ramp length,
                        // and from then on the amplitude is pinned to the peak.
                        if (tick_reg < ramp_ticks_reg) begin
                            tick_next = tick_inc;
                            amp_next  = amp_sum[AMP_BITS] ? {AMP_BITS{1'b1}}
                                                          : amp_sum[AMP_BITS-1:0];
                        end else begin
                            amp_next  = peak_reg;
                        end
                        phase_next     = phase_reg + phase_step_reg;
                        ramp_done_next = (tick_next >= ramp_ticks_reg);
                        state_next     = ST_ROM;
                    end
                end
            end
            ST_ROM: begin
                state_next = ST_MSTART;
            end
            ST_MSTART: begin
                mul_start  = 1'b1;
                neg_next   = rom_word[SINE_MAG_BITS];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // A zero reference gives a zero offset even on a zero bus. When
                // the upper product bits reach the divisor the quotient is at
                // least 2^32, which also covers a zero bus voltage.
                if (product == '0) begin
                    q_next     = '0;
                    state_next = ST_DUTY;
                end else if (product[MUL_P_BITS-1:DIV_Q_BITS] >= bus_reg) begin
                    q_next     = Q_HALF;
                    state_next = ST_DUTY;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    q_next     = (quotient > Q_HALF) ? Q_HALF : quotient;
                    state_next = ST_DUTY;
                end
            end
            ST_DUTY: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_BITS'({ramp_done_reg, duty_val});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            amp_reg       <= '0;
            phase_reg     <= '0;
            ramp_done_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            amp_reg       <= amp_next;
            phase_reg     <= phase_next;
            ramp_done_reg <= ramp_done_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bus_reg     <= bus_next;
        neg_reg     <= neg_next;
        q_reg       <= q_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sim/tb_sine_pwm_duty_soft_start_top.sv
// Self-checking testbench for the sinusoidal PWM duty generator with soft-start ramp.
`timescale 1ns / 1ps

module tb_sine_pwm_duty_soft_start_top;

    // Clock and run-length figures. The settle time outlasts the slowest enabled
    // tick, so it covers any tick still in flight.
    localparam int SETTLE_CYCLES   = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_WAIT        = 17;
    localparam int RAND_PHASES     = 12;
    localparam int TICKS_PER_PHASE = 50;

    // Bit positions of the result fields inside m_tdata.
    localparam int DUTY_LSB = 0;
    localparam int DONE_BIT = 16;

    // Fixed-point constants of the duty calculation.
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] HALF_Q32  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] DUTY_FULL = (64'd1 << spwm_pkg::DUTY_BITS) - 64'd1;

    // Odd quarter-wave polynomial for the sine table, Q30.
    localparam logic [63:0] K1 = 64'd1686629713;
    localparam logic [63:0] K3 = 64'd693598669;
    localparam logic [63:0] K5 = 64'd85569306;
    localparam logic [63:0] K7 = 64'd5026996;
    localparam logic [63:0] K9 = 64'd172274;

    // One expected result as it should leave the master side.
    typedef struct packed {
        logic [15:0] duty;
        logic        done;
    } duty_exp_t;

    // One row of the directed stimulus: either a register write or a tick.
    // A pinned tick carries a hand-derived result instead of the predicted one.
    typedef struct packed {
        bit          is_write;
        logic [7:0]  reg_idx;
        logic [31:0] reg_val;
        logic        en;
        logic [15:0] bus;
        bit          pinned;
        logic [15:0] pin_duty;
        logic        pin_done;
    } dir_row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [spwm_pkg::S_TDATA_BITS-1:0]   s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [spwm_pkg::M_TDATA_BITS-1:0]   m_tdata;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [spwm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [spwm_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    // Predictor copy of the configuration registers.
    logic [15:0] reg_ramp_ticks;
    logic [23:0] reg_amp_step;
    logic [31:0] reg_peak_amp;
    logic [15:0] reg_phase_step;

    // Predictor copy of the generator state.
    logic [15:0] gen_ticks;
    logic [31:0] gen_amp;
    logic [15:0] gen_phase;

    // Expected duty results, oldest first.
    duty_exp_t duty_expect_q [$];
    dir_row_t  dir_tab [$];

    // Shared control between the stimulus and the result side.
    bit burst_mode;
    bit hold_req;

    int mismatch_count;
    int results_seen;
    int ticks_offered;
    int reg_writes;

    sine_pwm_duty_soft_start_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Register writes land in the predictor only once the transfer happens.
    // Indexes outside the register map are dropped, as the block does.
    function automatic void apply_register(logic [7:0] idx, logic [31:0] val);
        case (idx)
            spwm_pkg::CFG_RAMP_TICKS:     reg_ramp_ticks = val[15:0];
            spwm_pkg::CFG_AMPLITUDE_STEP: reg_amp_step   = val[23:0];
            spwm_pkg::CFG_PEAK_AMPLITUDE: reg_peak_amp   = val;
            spwm_pkg::CFG_PHASE_STEP:     reg_phase_step = val[15:0];
            default: ;
        endcase
    endfunction

    // Sine of the table entry that a phase selects: {negative, magnitude 0..32768}.
    // The phase picks a table slot, the slot angle is folded onto a quarter wave
    // and the polynomial is evaluated in Q30 with truncating products.
    function automatic logic [16:0] sine_lookup(logic [15:0] ph);
        logic [63:0] slot;
        logic [63:0] ang;
        logic [63:0] rem;
        logic [63:0] z;
        logic [63:0] zsq;
        logic [63:0] poly;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quadrant;
        slot     = (64'(ph) * 64'(spwm_pkg::SINE_TABLE_DEPTH)) >> 16;
        ang      = (slot << 32) / 64'(spwm_pkg::SINE_TABLE_DEPTH);
        quadrant = ang[31:30];
        rem      = ang & (ONE_Q30 - 64'd1);
        z        = quadrant[0] ? (ONE_Q30 - rem) : rem;
        zsq      = (z * z) >> 30;
        poly     = K9;
        poly     = K7 - ((zsq * poly) >> 30);
        poly     = K5 - ((zsq * poly) >> 30);
        poly     = K3 - ((zsq * poly) >> 30);
        poly     = K1 - ((zsq * poly) >> 30);
        s        = (z * poly) >> 30;
        mag      = (s + 64'd16384) >> 15;
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        return {quadrant[1] && (mag != 64'd0), mag[15:0]};
    endfunction

    // Advances the generator by one enabled tick and returns the duty it produces.
    function automatic duty_exp_t advance_generator(logic [15:0] bus);
        logic [32:0] sum;
        logic [16:0] sw;
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] d;
        logic [63:0] scaled;
        duty_exp_t   r;
        // Soft-start: count and grow the amplitude, or pin it to the peak.
        if (gen_ticks < reg_ramp_ticks) begin
            sum       = {1'b0, gen_amp} + {9'd0, reg_amp_step};
            gen_ticks = gen_ticks + 16'd1;
            gen_amp   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
            gen_amp = reg_peak_amp;
        end
        gen_phase = gen_phase + reg_phase_step;
        sw        = sine_lookup(gen_phase);
        prod      = 64'(gen_amp) * 64'(sw[15:0]);
        // A zero product wins over a zero bus; a zero bus saturates the ratio.
        if (prod == 64'd0) begin
            q = 64'd0;
        end else if (bus == 16'd0) begin
            q = HALF_Q32;
        end else begin
            q = prod / 64'(bus);
            if (q > HALF_Q32) begin
                q = HALF_Q32;
            end
        end
        d      = sw[16] ? (HALF_Q32 - q) : (HALF_Q32 + q);
        scaled = (d * DUTY_FULL) >> 32;
        r.duty = scaled[15:0];
        r.done = (gen_ticks >= reg_ramp_ticks);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic dir_row_t write_row(logic [7:0] idx, logic [31:0] val);
        dir_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    function automatic dir_row_t tick_row(logic en, logic [15:0] bus);
        dir_row_t r;
        r     = '0;
        r.en  = en;
        r.bus = bus;
        return r;
    endfunction

    function automatic dir_row_t pinned_row(logic [15:0] bus, logic [15:0] duty, logic done);
        dir_row_t r;
        r          = tick_row(1'b1, bus);
        r.pinned   = 1'b1;
        r.pin_duty = duty;
        r.pin_done = done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offers one tick on the slave side after a random gap, none in burst mode, and
    // waits for the transfer. The valid stays high afterwards so that a back-to-back
    // tick never lowers and raises it within one time step.
    task automatic send_tick(input logic en, input logic [15:0] bus, input bit pinned,
                             input logic [15:0] pin_duty, input logic pin_done);
        int        gap;
        duty_exp_t e;
        gap = burst_mode ? 0 : $urandom_range(MAX_WAIT, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, bus, en};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_offered++;
        if (en) begin
            e = advance_generator(bus);
            if (pinned) begin
                e.duty = pin_duty;
                e.done = pin_done;
            end
            duty_expect_q.push_back(e);
        end
    endtask

    // Brings the block to idle: no tick offered, every expected result
    // delivered, then enough cycles for a disabled tick still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (duty_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write transfer; valid drops after the transfer, before the next write.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(idx, val);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Picks a new random setting, with the extremes well represented. The upper
    // data bits of the narrow registers carry junk that the block must drop.
    task automatic retune();
        logic [31:0] v;
        if ($urandom_range(3, 0) != 0) begin
            case ($urandom_range(3, 0))
                0:       v = 32'd0;
                1:       v = 32'h0000_FFFF;
                // Puts the ramp end 1 to 40 ticks past the current count.
                2:       v = 32'(gen_ticks) + $urandom_range(40, 1);
                default: v = $urandom();
            endcase
            write_reg(spwm_pkg::CFG_RAMP_TICKS, {16'($urandom_range(65535, 0)), v[15:0]});
        end
        if ($urandom_range(3, 0) != 0) begin
            case ($urandom_range(3, 0))
                0:       v = 32'd0;
                1:       v = 32'h00FF_FFFF;
                2:       v = $urandom_range(1 << 20, 1);
                default: v = $urandom();
            endcase
            write_reg(spwm_pkg::CFG_AMPLITUDE_STEP, v);
        end
        if ($urandom_range(3, 0) != 0) begin
            case ($urandom_range(2, 0))
                0:       v = 32'd0;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom();
            endcase
            write_reg(spwm_pkg::CFG_PEAK_AMPLITUDE, v);
        end
        if ($urandom_range(3, 0) != 0) begin
            case ($urandom_range(3, 0))
                0:       v = 32'd0;
                1:       v = 32'h0000_FFFF;
                2:       v = $urandom_range(512, 1);
                default: v = $urandom();
            endcase
            write_reg(spwm_pkg::CFG_PHASE_STEP, {16'($urandom_range(65535, 0)), v[15:0]});
        end
        // Now and then a write outside the register map, which must be ignored.
        if ($urandom_range(2, 0) == 0) begin
            write_reg(8'($urandom_range(255, 4)), $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, a long hold-off on request, and checking
    // ------------------------------------------------------------------

    initial begin
        int        wait_cycles;
        duty_exp_t want;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            // A long hold-off lets the block fill up and push back on its input.
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            wait_cycles = burst_mode ? 0 : $urandom_range(MAX_WAIT, 0);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            // A result transfer happened at this edge.
            results_seen++;
            if (duty_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result transfer with nothing expected: m_tdata=%h",
                         $time, m_tdata);
            end else begin
                want = duty_expect_q.pop_front();
                if (m_tdata[DUTY_LSB +: 16] !== want.duty) begin
                    mismatch_count++;
                    $display("%0t: duty mismatch: expected %0d, actual %0d",
                             $time, want.duty, m_tdata[DUTY_LSB +: 16]);
                end
                if (m_tdata[DONE_BIT] !== want.done) begin
                    mismatch_count++;
                    $display("%0t: ramp_done mismatch: expected %0b, actual %0b",
                             $time, want.done, m_tdata[DONE_BIT]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, wrap-up
    // ------------------------------------------------------------------

    initial begin
        int          p;
        int          n;
        logic        en;
        logic [15:0] bus;
        dir_row_t    row;

        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        aresetn        = 1'b0;
        burst_mode     = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        ticks_offered  = 0;
        reg_writes     = 0;

        // Predictor state after reset: register defaults, generator cleared.
        reg_ramp_ticks = 16'd25000;
        reg_amp_step   = 24'd11389;
        reg_peak_amp   = 32'd284718751;
        reg_phase_step = 16'd131;
        gen_ticks      = '0;
        gen_amp        = '0;
        gen_phase      = '0;

        // Directed part. With the phase step at zero the phase sits at zero, so
        // the sine is zero and the duty is 32767, one half of full scale rounded down.
        dir_tab.push_back(write_row(spwm_pkg::CFG_PHASE_STEP, 32'd0));
        dir_tab.push_back(tick_row(1'b0, 16'h1234));               // disabled: no result
        dir_tab.push_back(pinned_row(16'hFFFF, 16'd32767, 1'b0));  // first tick after reset
        dir_tab.push_back(pinned_row(16'h0000, 16'd32767, 1'b0));  // zero bus, zero reference
        // A quarter-turn step walks the four quadrant boundaries in turn.
        dir_tab.push_back(write_row(spwm_pkg::CFG_PHASE_STEP, 32'd16384));
        dir_tab.push_back(pinned_row(16'h0000, 16'd65535, 1'b0));  // zero bus, positive peak
        dir_tab.push_back(pinned_row(16'h0000, 16'd32767, 1'b0));  // half turn, zero sine
        dir_tab.push_back(pinned_row(16'h0000, 16'd0, 1'b0));      // zero bus, negative peak
        dir_tab.push_back(pinned_row(16'h0001, 16'd32767, 1'b0));  // phase wraps back to zero
        dir_tab.push_back(pinned_row(16'h0001, 16'd65535, 1'b0));  // ratio beyond one, positive
        dir_tab.push_back(tick_row(1'b0, 16'h0000));               // disabled: phase holds
        dir_tab.push_back(tick_row(1'b1, 16'h3200));
        dir_tab.push_back(pinned_row(16'h0001, 16'd0, 1'b0));      // ratio beyond one, negative
        // Ramp length dropped below the count already reached, peak at zero.
        dir_tab.push_back(write_row(spwm_pkg::CFG_RAMP_TICKS, 32'd0));
        dir_tab.push_back(write_row(spwm_pkg::CFG_PEAK_AMPLITUDE, 32'd0));
        dir_tab.push_back(pinned_row(16'h0100, 16'd32767, 1'b1));
        // Largest peak and phase step.
        dir_tab.push_back(write_row(spwm_pkg::CFG_PEAK_AMPLITUDE, 32'hFFFF_FFFF));
        dir_tab.push_back(write_row(spwm_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF));
        dir_tab.push_back(tick_row(1'b1, 16'hFFFF));
        dir_tab.push_back(tick_row(1'b1, 16'h0001));
        dir_tab.push_back(tick_row(1'b1, 16'h0000));
        // The ramp restarts from the largest amplitude, so the sum saturates.
        dir_tab.push_back(write_row(spwm_pkg::CFG_AMPLITUDE_STEP, 32'h00FF_FFFF));
        dir_tab.push_back(write_row(spwm_pkg::CFG_RAMP_TICKS, 32'h0000_FFFF));
        dir_tab.push_back(tick_row(1'b1, 16'h8000));
        dir_tab.push_back(tick_row(1'b1, 16'h3200));
        // Writes outside the register map change nothing.
        dir_tab.push_back(write_row(8'd4, 32'hFFFF_FFFF));
        dir_tab.push_back(write_row(8'hFF, 32'h0000_0000));
        dir_tab.push_back(tick_row(1'b1, 16'h3200));
        dir_tab.push_back(write_row(spwm_pkg::CFG_AMPLITUDE_STEP, 32'd0));
        dir_tab.push_back(tick_row(1'b1, 16'h2A00));
        dir_tab.push_back(tick_row(1'b1, 16'h7FFF));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.is_write) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_tick(row.en, row.bus, row.pinned, row.pin_duty, row.pin_done);
            end
        end

        // Random part: each phase starts from idle with a fresh setting. Every
        // fourth phase runs without gaps on either side; the second phase
        // opens with a long stall on the result side.
        for (p = 0; p < RAND_PHASES; p++) begin
            settle();
            retune();
            burst_mode = (p % 4 == 3);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                en = ($urandom_range(4, 0) != 0);
                case ($urandom_range(19, 0))
                    0:       bus = 16'h0000;
                    1:       bus = 16'hFFFF;
                    2, 3:    bus = 16'($urandom_range(15, 1));
                    default: bus = 16'($urandom());
                endcase
                send_tick(en, bus, 1'b0, 16'd0, 1'b0);
            end
        end

        burst_mode = 1'b0;
        settle();

        $display("Run covered %0d ticks, %0d checked results and %0d register writes,",
                 ticks_offered, results_seen, reg_writes);
        $display("across quadrant edges, zero and saturated ratios, ramp ends and a long stall.");
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (about one millisecond).
    initial begin
        #20_000_000;
        $display("Timeout with %0d results still expected", duty_expect_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
